### src/assert_macros.svh
// Assertion macros shared by the checker files of the fan duty controller.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FDHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fdhc: property check failed");

// Condition must never be seen at a clock edge outside reset.
`define FDHC_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fdhc: forbidden condition seen");

`endif

### src/fdhc_pkg.sv
// Shared widths, mode codes, register indexes and reset values of the
// fan duty hysteresis controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdhc_pkg;

  // field widths
  localparam int DutyW   = 8;
  localparam int SampleW = 12;
  localparam int RawW    = 16;
  localparam int ModeW   = 2;

  // arithmetic widths of the linear map
  localparam int ProdW     = SampleW + DutyW;   // |sample-start| * |max-min|
  localparam int ValW      = ProdW + 2;         // signed mapped value
  localparam int DivSteps  = ProdW;             // one quotient bit per step
  localparam int DivCntW   = $clog2(DivSteps);

  // configuration port
  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam int RegIdxW = 2;

  typedef logic [DutyW-1:0]   duty_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  localparam mode_t ModeInit  = 2'd0;
  localparam mode_t ModeIdle  = 2'd1;
  localparam mode_t ModeRun   = 2'd2;
  localparam mode_t ModeFault = 2'd3;

  localparam reg_idx_t RegStart  = 2'd0;
  localparam reg_idx_t RegStop   = 2'd1;
  localparam reg_idx_t RegMinDut = 2'd2;
  localparam reg_idx_t RegMaxDut = 2'd3;

  localparam sample_t SampleFull  = 12'd4095;
  localparam sample_t StartReset  = 12'd2048;
  localparam sample_t StopReset   = 12'd1843;
  localparam duty_t   MinDutReset = 8'd64;
  localparam duty_t   MaxDutReset = 8'd255;

endpackage

`default_nettype wire

### src/fan_duty_hysteresis_controller_core.sv
// Top level of the fan duty hysteresis controller: mode sequencer, one
// shared multiplier/divider datapath and the APB-style register file.
// Depends on fdhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// --------  ---------  ---------------------------  -----------------------------------
// sample    in         in_valid_i / in_ready_o      temp_sample_i
// result    out        out_valid_o / out_ready_i    duty_out_o, mode_out_o, stored_duty_o
// config    in         psel/penable/pwrite, pready  paddr, pwdata -> prdata
//
// A sample that needs no duty map shows its result after its transfer through
// evaluate and commit; a mapped sample passes evaluate, multiply, 20 steps of
// the restoring divider, clamp and commit.
// With start at full scale the map is skipped: evaluate, clamp, commit.
// in_ready_o stays low until commit; a held result delays only the commit itself.
// Reset (rst_ni low, asynchronous) gives mode init, kept duty zero, register defaults.

module fan_duty_hysteresis_controller_core (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  // sample channel
  input  wire  logic                        in_valid_i,
  output       logic                        in_ready_o,
  input  wire  logic [fdhc_pkg::RawW-1:0]   temp_sample_i,
  // result channel
  output       logic                        out_valid_o,
  input  wire  logic                        out_ready_i,
  output       logic [fdhc_pkg::DutyW-1:0]  duty_out_o,
  output       logic [fdhc_pkg::ModeW-1:0]  mode_out_o,
  output       logic [fdhc_pkg::DutyW-1:0]  stored_duty_o,
  // configuration port
  input  wire  logic                        psel,
  input  wire  logic                        penable,
  input  wire  logic                        pwrite,
  input  wire  logic [fdhc_pkg::AddrW-1:0]  paddr,
  input  wire  logic [fdhc_pkg::DataW-1:0]  pwdata,
  output       logic [fdhc_pkg::DataW-1:0]  prdata,
  output       logic                        pready
);

  localparam int SampleW = fdhc_pkg::SampleW;
  localparam int DutyW   = fdhc_pkg::DutyW;
  localparam int ProdW   = fdhc_pkg::ProdW;
  localparam int ValW    = fdhc_pkg::ValW;
  localparam int DivCntW = fdhc_pkg::DivCntW;
  localparam int RawW    = fdhc_pkg::RawW;
  localparam int DataW   = fdhc_pkg::DataW;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CLAMP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  fdhc_pkg::sample_t start_q, stop_q;
  fdhc_pkg::duty_t   min_q, max_q;
  fdhc_pkg::reg_idx_t reg_idx;
  logic cfg_wr;

  assign reg_idx = paddr[fdhc_pkg::AddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= fdhc_pkg::StartReset;
      stop_q  <= fdhc_pkg::StopReset;
      min_q   <= fdhc_pkg::MinDutReset;
      max_q   <= fdhc_pkg::MaxDutReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        fdhc_pkg::RegStart:  start_q <= pwdata[SampleW-1:0];
        fdhc_pkg::RegStop:   stop_q  <= pwdata[SampleW-1:0];
        fdhc_pkg::RegMinDut: min_q   <= pwdata[DutyW-1:0];
        fdhc_pkg::RegMaxDut: max_q   <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fdhc_pkg::RegStart:  prdata = {{(DataW-SampleW){1'b0}}, start_q};
      fdhc_pkg::RegStop:   prdata = {{(DataW-SampleW){1'b0}}, stop_q};
      fdhc_pkg::RegMinDut: prdata = {{(DataW-DutyW){1'b0}}, min_q};
      fdhc_pkg::RegMaxDut: prdata = {{(DataW-DutyW){1'b0}}, max_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0]            state_q, state_d;
  fdhc_pkg::mode_t       mode_q, mode_d;
  fdhc_pkg::duty_t       kept_q, kept_d;
  logic                  out_valid_q, out_valid_d;

  logic [RawW-1:0]       sample_q, sample_d;
  logic                  full_q, full_d;        // start at full scale: map gives max
  logic                  neg_q, neg_d;          // sign of the quotient
  logic [ProdW-1:0]      quo_q, quo_d;          // dividend shifting out, quotient in
  logic [SampleW-1:0]    rem_q, rem_d;
  logic [SampleW-1:0]    den_q, den_d;
  logic [DivCntW-1:0]    cnt_q, cnt_d;
  fdhc_pkg::mode_t       res_mode_q, res_mode_d;
  fdhc_pkg::duty_t       res_duty_q, res_duty_d;
  fdhc_pkg::duty_t       res_kept_q, res_kept_d;
  fdhc_pkg::duty_t       duty_out_q, duty_out_d;
  fdhc_pkg::mode_t       mode_out_q, mode_out_d;
  fdhc_pkg::duty_t       stored_q, stored_d;

  // evaluate: classify the sample and apply the hysteresis
  fdhc_pkg::sample_t s12;
  logic              s_ok;
  fdhc_pkg::mode_t   mode_eff;

  assign s12      = sample_q[SampleW-1:0];
  assign s_ok     = (sample_q != '0) && (sample_q[RawW-1:SampleW] == '0);
  assign mode_eff = (mode_q == fdhc_pkg::ModeFault) ? fdhc_pkg::ModeIdle : mode_q;

  // multiply: sign-magnitude of (sample - start) * (max - min)
  logic [SampleW:0]   diff;
  logic [SampleW:0]   diff_neg;
  logic [SampleW-1:0] diff_mag;
  logic [DutyW:0]     span;
  logic [DutyW:0]     span_neg;
  logic [DutyW-1:0]   span_mag;
  logic [ProdW-1:0]   prod;

  assign diff     = {1'b0, s12} - {1'b0, start_q};
  assign diff_neg = -diff;
  assign diff_mag = diff[SampleW] ? diff_neg[SampleW-1:0] : diff[SampleW-1:0];
  assign span     = {1'b0, max_q} - {1'b0, min_q};
  assign span_neg = -span;
  assign span_mag = span[DutyW] ? span_neg[DutyW-1:0] : span[DutyW-1:0];
  assign prod     = ProdW'(diff_mag) * ProdW'(span_mag);

  // divide: one restoring step per cycle on the subtractor
  logic [SampleW:0]   shifted;
  logic [SampleW+1:0] trial;
  logic               trial_ge;

  assign shifted  = {rem_q, quo_q[ProdW-1]};
  assign trial    = {1'b0, shifted} - {2'b0, den_q};
  assign trial_ge = ~trial[SampleW+1];

  // clamp: add min, then bound by min first, max second
  logic [ValW-1:0]  ext_lo, ext_hi, ext_q, val_map, val;
  fdhc_pkg::duty_t  clamped;

  assign ext_lo  = {{(ValW-DutyW){1'b0}}, min_q};
  assign ext_hi  = {{(ValW-DutyW){1'b0}}, max_q};
  assign ext_q   = {2'b0, quo_q};
  assign val_map = neg_q ? (ext_lo - ext_q) : (ext_lo + ext_q);
  assign val     = full_q ? ext_hi : val_map;

  always_comb begin
    if (val[ValW-1] || (val < ext_lo)) begin
      clamped = min_q;
    end else if (val > ext_hi) begin
      clamped = max_q;
    end else begin
      clamped = val[DutyW-1:0];
    end
  end

  logic out_free;
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    kept_d      = kept_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    full_d      = full_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    res_mode_d  = res_mode_q;
    res_duty_d  = res_duty_q;
    res_kept_d  = res_kept_q;
    duty_out_d  = duty_out_q;
    mode_out_d  = mode_out_q;
    stored_d    = stored_q;

    // drop the held result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d = temp_sample_i;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        res_duty_d = '0;
        res_kept_d = kept_q;
        full_d     = (start_q == fdhc_pkg::SampleFull);
        state_d    = S_DONE;
        if (!s_ok) begin
          res_mode_d = fdhc_pkg::ModeFault;
          res_kept_d = '0;
        end else if (mode_eff == fdhc_pkg::ModeInit) begin
          res_mode_d = fdhc_pkg::ModeIdle;
        end else if (mode_eff == fdhc_pkg::ModeIdle) begin
          res_mode_d = (s12 >= start_q) ? fdhc_pkg::ModeRun : fdhc_pkg::ModeIdle;
        end else if (s12 < stop_q) begin
          res_mode_d = fdhc_pkg::ModeIdle;
        end else begin
          // running and at or above stop: map the sample
          res_mode_d = fdhc_pkg::ModeRun;
          state_d    = (start_q == fdhc_pkg::SampleFull) ? S_CLAMP : S_MUL;
        end
      end
      S_MUL: begin
        quo_d   = prod;
        neg_d   = diff[SampleW] ^ span[DutyW];
        rem_d   = '0;
        den_d   = fdhc_pkg::SampleFull - start_q;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        quo_d = {quo_q[ProdW-2:0], trial_ge};
        rem_d = trial_ge ? trial[SampleW-1:0] : shifted[SampleW-1:0];
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(fdhc_pkg::DivSteps - 1)) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        res_duty_d = clamped;
        res_kept_d = clamped;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // commit state and load the output register when it is free
        if (out_free) begin
          mode_d      = res_mode_q;
          kept_d      = res_kept_q;
          duty_out_d  = res_duty_q;
          mode_out_d  = res_mode_q;
          stored_d    = res_kept_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= fdhc_pkg::ModeInit;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    full_q     <= full_d;
    neg_q      <= neg_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    cnt_q      <= cnt_d;
    res_mode_q <= res_mode_d;
    res_duty_q <= res_duty_d;
    res_kept_q <= res_kept_d;
    duty_out_q <= duty_out_d;
    mode_out_q <= mode_out_d;
    stored_q   <= stored_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign duty_out_o    = duty_out_q;
  assign mode_out_o    = mode_out_q;
  assign stored_duty_o = stored_q;

endmodule

`default_nettype wire

### src/fdhc_checker.sv
// Port-level checks on the fan duty controller, bound to its top level.
// Depends on fdhc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fdhc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [fdhc_pkg::DutyW-1:0]  duty_out_o,
  input wire logic [fdhc_pkg::ModeW-1:0]  mode_out_o,
  input wire logic [fdhc_pkg::DutyW-1:0]  stored_duty_o
);

  logic [2*fdhc_pkg::DutyW+fdhc_pkg::ModeW-1:0] out_payload;
  logic                                         out_fault;

  assign out_payload = {duty_out_o, mode_out_o, stored_duty_o};
  assign out_fault   = out_valid_o && (mode_out_o == fdhc_pkg::ModeFault);

  // a held result keeps its payload until taken
  `FDHC_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_payload)))

  // one sample at a time: ready drops after each transfer in
  `FDHC_ASSERT(a_busy_after_in, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // the fan is driven only while running
  `FDHC_ASSERT(a_duty_run, (out_valid_o && duty_out_o != '0) |-> mode_out_o == fdhc_pkg::ModeRun)

  // a fault clears both duties
  `FDHC_ASSERT(a_fault_zero, out_fault |-> (duty_out_o == '0 && stored_duty_o == '0))

  // every result leaves init behind
  `FDHC_NEVER(a_no_init, out_valid_o && mode_out_o == fdhc_pkg::ModeInit)

endmodule

bind fan_duty_hysteresis_controller_core fdhc_checker u_fdhc_checker (.*);

`default_nettype wire
